/* rtl/core/nts_pkg.sv */
package nts_pkg;

    // Table depth and angle format
    localparam int MAX_ENTRIES = 64;
    localparam int ANGLE_BITS  = 16;
    localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] HALF_TURN    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

    // Sine polynomial coefficients, Q15
    localparam logic [16:0] SIN_A   = 17'd51472;
    localparam logic [16:0] SIN_B   = 17'd21024;
    localparam logic [16:0] SIN_C   = 17'd2320;
    localparam logic [16:0] ONE_Q15 = 17'd32768;

    // Datapath widths
    localparam int LOG_W = 14;
    localparam int SIN_W = 18;
    localparam int MA_W  = 32;
    localparam int MB_W  = 32;
    localparam int P_W   = MA_W + MB_W;
    localparam int DOT_W = 50;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] entry_id;
        logic [15:0] zenith_min;
        logic [15:0] zenith_max;
        logic [15:0] azimuth_min;
        logic [15:0] azimuth_max;
        logic [31:0] entry_energy;
        logic [15:0] event_zenith;
        logic [15:0] event_azimuth;
        logic [31:0] event_energy;
    } t_req;

    typedef struct packed {
        logic [31:0] chosen_id;
        logic        found;
        logic        table_full;
    } t_res;

    // One stored table entry: the zenith centre is kept as its sine and cosine
    typedef struct packed {
        logic [31:0]             id;
        logic [ANGLE_BITS-1:0]   azimuth;
        logic [LOG_W-1:0]        log_energy;
        logic signed [SIN_W-1:0] sin_zenith;
        logic signed [SIN_W-1:0] cos_zenith;
    } t_entry;

endpackage

/* rtl/core/nts_if.sv */
interface nts_req_if;
    logic          valid;
    logic          ready;
    nts_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface nts_res_if;
    logic          valid;
    logic          ready;
    nts_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/nts_mul.sv */
module nts_mul (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [nts_pkg::MA_W-1:0]  i_a,
    input  logic signed [nts_pkg::MB_W-1:0]  i_b,
    output logic signed [nts_pkg::P_W-1:0]   o_p
);
    import nts_pkg::*;

    logic signed [P_W-1:0] r_p;

    // Shared signed multiplier with a registered product.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;
endmodule

/* rtl/core/nts_table.sv */
module nts_table (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [nts_pkg::ADDR_W-1:0]    i_wr_addr,
    input  nts_pkg::t_entry               i_wr_data,
    input  logic                          i_rd_en,
    input  logic [nts_pkg::ADDR_W-1:0]    i_rd_addr,
    output nts_pkg::t_entry               o_rd_data
);
    import nts_pkg::*;

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

/* rtl/core/nearest_table_select.sv */
// Nearest-entry table selector. A load request stores one entry (identifier,
// direction centre, base-2 log energy) in the next free slot of a 64-entry
// table; a clear request empties it; a query request walks the loaded entries
// in slot order and returns the identifier of the chosen one. Every request
// gives exactly one result. Every product runs through one shared registered
// multiplier under a sequencer: the log of an energy is taken by normalising
// shifts and then by repeated squaring of the mantissa, each sine or cosine
// by a chain of products, and a query does a table read and a closeness
// product chain for each loaded entry. The block takes no new request while
// one is being worked on, but it does take one while the previous result
// still waits at the output register.
module nearest_table_select (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nts_req_if.sink     i_req,
    nts_res_if.source   o_res
);
    import nts_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_NORM, ST_SQ, ST_POSTLOG, ST_SIN0, ST_SIN1, ST_SIN2, ST_SIN3,
        ST_SIN4, ST_MUL, ST_WRITE, ST_READ, ST_LATCH, ST_SS, ST_CC, ST_DOT,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        JOB_LZS, JOB_LZC, JOB_QES, JOB_QEC, JOB_CD
    } t_job;

    t_state r_state, r_ret;
    t_job   r_job;

    logic                    r_is_load;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_i;
    logic [31:0]             r_id;
    logic [ANGLE_BITS-1:0]   r_zc, r_ac, r_ez, r_ea, r_ang;
    logic [31:0]             r_v;
    logic [4:0]              r_ip;
    logic [7:0]              r_frac;
    logic [2:0]              r_k;
    logic [LOG_W-1:0]        r_log;
    logic [16:0]             r_x, r_x2;
    logic                    r_neg;
    logic signed [SIN_W-1:0] r_sz, r_cz, r_se, r_ce, r_cd;
    logic signed [MA_W-1:0]  r_ma, r_ss, r_cc;
    logic signed [MB_W-1:0]  r_mb;
    t_entry                  r_ent;
    logic signed [DOT_W-1:0] r_best_dot;
    logic [LOG_W-1:0]        r_best_de;
    logic [31:0]             r_chosen;
    logic                    r_found, r_full;
    logic                    r_ovalid;
    t_res                    r_res;

    logic signed [P_W-1:0]   mul_p;
    t_entry                  wr_data, rd_data;

    // Angle folding for the sine evaluation
    logic [1:0]              sin_q;
    logic [16:0]             sin_x0, sin_x;
    logic [17:0]             sin_mag;
    logic signed [SIN_W-1:0] sin_val;
    logic [30:0]             sq_m;
    logic signed [DOT_W-1:0] dot;
    logic [LOG_W-1:0]        de;

    // Request payload views
    logic [16:0]           zsum, asum;
    logic [ANGLE_BITS-1:0] az_mid;
    logic [31:0]           energy_in;

    assign sin_q  = r_ang[ANGLE_BITS-1 -: 2];
    assign sin_x0 = 17'({r_ang[ANGLE_BITS-3:0], 15'b0} >> (ANGLE_BITS - 2));
    assign sin_x  = sin_q[0] ? (ONE_Q15 - sin_x0) : sin_x0;

    assign sin_mag = mul_p[32:15];
    assign sin_val = r_neg ? -$signed(sin_mag) : $signed(sin_mag);

    // A squared mantissa of two or more is halved and yields a one bit.
    assign sq_m = mul_p[61] ? mul_p[61:31] : mul_p[60:30];

    assign dot = DOT_W'(mul_p) + (DOT_W'(r_cc) <<< 15);
    assign de  = (r_ent.log_energy > r_log) ? (r_ent.log_energy - r_log)
                                            : (r_log - r_ent.log_energy);

    assign zsum   = 17'(i_req.data.zenith_min[ANGLE_BITS-1:0])
                  + 17'(i_req.data.zenith_max[ANGLE_BITS-1:0]);
    assign asum   = 17'(i_req.data.azimuth_min[ANGLE_BITS-1:0])
                  + 17'(i_req.data.azimuth_max[ANGLE_BITS-1:0]);
    assign az_mid = asum[ANGLE_BITS:1]
                  + ((i_req.data.azimuth_max[ANGLE_BITS-1:0]
                      < i_req.data.azimuth_min[ANGLE_BITS-1:0]) ? HALF_TURN
                                                               : ANGLE_BITS'(0));
    assign energy_in = (t_action'(i_req.data.action) == ACT_LOAD)
                     ? i_req.data.entry_energy : i_req.data.event_energy;

    assign wr_data.id         = r_id;
    assign wr_data.azimuth    = r_ac;
    assign wr_data.log_energy = r_log;
    assign wr_data.sin_zenith = r_sz;
    assign wr_data.cos_zenith = r_cz;

    nts_mul u_mul (
        .i_clk (i_clk),
        .i_en  (r_state == ST_MUL),
        .i_a   (r_ma),
        .i_b   (r_mb),
        .o_p   (mul_p)
    );

    nts_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == ST_WRITE),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (r_state == ST_READ),
        .i_rd_addr (r_i[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // The finishing state decides the valid flag itself.
            if (r_ovalid && o_res.ready && r_state != ST_FINISH) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_chosen  <= '0;
                        r_found   <= 1'b0;
                        r_full    <= 1'b0;
                        r_id      <= i_req.data.entry_id;
                        r_zc      <= zsum[ANGLE_BITS:1];
                        r_ac      <= az_mid;
                        r_ez      <= i_req.data.event_zenith[ANGLE_BITS-1:0];
                        r_ea      <= i_req.data.event_azimuth[ANGLE_BITS-1:0];
                        r_v       <= energy_in;
                        r_ip      <= 5'd31;
                        r_log     <= '0;
                        r_is_load <= (t_action'(i_req.data.action) == ACT_LOAD);
                        case (t_action'(i_req.data.action))
                            ACT_LOAD: begin
                                if (r_count >= CNT_W'(MAX_ENTRIES)) begin
                                    r_full  <= 1'b1;
                                    r_state <= ST_FINISH;
                                end else if (energy_in == 32'd0) begin
                                    r_state <= ST_POSTLOG;
                                end else begin
                                    r_state <= ST_NORM;
                                end
                            end
                            ACT_QUERY: begin
                                r_state <= (energy_in == 32'd0) ? ST_POSTLOG : ST_NORM;
                            end
                            ACT_CLEAR: begin
                                r_count <= '0;
                                r_state <= ST_FINISH;
                            end
                            default: begin
                                r_state <= ST_FINISH;
                            end
                        endcase
                    end
                end
                // Shift the energy up until its top bit is set.
                ST_NORM: begin
                    if (r_v[31]) begin
                        r_ma    <= MA_W'(r_v[31:1]);
                        r_mb    <= MB_W'(r_v[31:1]);
                        r_k     <= '0;
                        r_frac  <= '0;
                        r_ret   <= ST_SQ;
                        r_state <= ST_MUL;
                    end else begin
                        r_v  <= {r_v[30:0], 1'b0};
                        r_ip <= r_ip - 5'd1;
                    end
                end
                // One fraction bit of the log per squaring of the mantissa.
                ST_SQ: begin
                    r_frac <= {r_frac[6:0], mul_p[61]};
                    if (r_k == 3'd7) begin
                        r_log   <= LOG_W'({r_ip, r_frac[6:0], mul_p[61]});
                        r_state <= ST_POSTLOG;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_ma    <= MA_W'(sq_m);
                        r_mb    <= MB_W'(sq_m);
                        r_ret   <= ST_SQ;
                        r_state <= ST_MUL;
                    end
                end
                ST_POSTLOG: begin
                    if (r_is_load) begin
                        r_ang <= r_zc;
                        r_job <= JOB_LZS;
                    end else begin
                        r_ang <= r_ez;
                        r_job <= JOB_QES;
                    end
                    r_state <= ST_SIN0;
                end
                // Sine: x^2, then the polynomial in Horner form.
                ST_SIN0: begin
                    r_x     <= sin_x;
                    r_neg   <= sin_q[1];
                    r_ma    <= MA_W'(sin_x);
                    r_mb    <= MB_W'(sin_x);
                    r_ret   <= ST_SIN1;
                    r_state <= ST_MUL;
                end
                ST_SIN1: begin
                    r_x2    <= mul_p[31:15];
                    r_ma    <= MA_W'(mul_p[31:15]);
                    r_mb    <= MB_W'(SIN_C);
                    r_ret   <= ST_SIN2;
                    r_state <= ST_MUL;
                end
                ST_SIN2: begin
                    r_ma    <= MA_W'(r_x2);
                    r_mb    <= MB_W'(SIN_B - mul_p[31:15]);
                    r_ret   <= ST_SIN3;
                    r_state <= ST_MUL;
                end
                ST_SIN3: begin
                    r_ma    <= MA_W'(r_x);
                    r_mb    <= MB_W'(SIN_A - mul_p[31:15]);
                    r_ret   <= ST_SIN4;
                    r_state <= ST_MUL;
                end
                ST_SIN4: begin
                    case (r_job)
                        JOB_LZS: begin
                            r_sz    <= sin_val;
                            r_ang   <= r_zc + QUARTER_TURN;
                            r_job   <= JOB_LZC;
                            r_state <= ST_SIN0;
                        end
                        JOB_LZC: begin
                            r_cz    <= sin_val;
                            r_state <= ST_WRITE;
                        end
                        JOB_QES: begin
                            r_se    <= sin_val;
                            r_ang   <= r_ez + QUARTER_TURN;
                            r_job   <= JOB_QEC;
                            r_state <= ST_SIN0;
                        end
                        JOB_QEC: begin
                            r_ce    <= sin_val;
                            r_i     <= '0;
                            r_state <= (r_count == '0) ? ST_FINISH : ST_READ;
                        end
                        default: begin
                            r_cd    <= sin_val;
                            r_ma    <= MA_W'(r_se);
                            r_mb    <= MB_W'(r_ent.sin_zenith);
                            r_ret   <= ST_SS;
                            r_state <= ST_MUL;
                        end
                    endcase
                end
                ST_MUL: begin
                    r_state <= r_ret;
                end
                ST_WRITE: begin
                    r_count <= r_count + CNT_W'(1);
                    r_state <= ST_FINISH;
                end
                ST_READ: begin
                    r_state <= ST_LATCH;
                end
                // Cosine of the azimuth difference for this entry.
                ST_LATCH: begin
                    r_ent   <= rd_data;
                    r_ang   <= rd_data.azimuth - r_ea + QUARTER_TURN;
                    r_job   <= JOB_CD;
                    r_state <= ST_SIN0;
                end
                ST_SS: begin
                    r_ss    <= MA_W'(mul_p);
                    r_ma    <= MA_W'(r_ce);
                    r_mb    <= MB_W'(r_ent.cos_zenith);
                    r_ret   <= ST_CC;
                    r_state <= ST_MUL;
                end
                ST_CC: begin
                    r_cc    <= MA_W'(mul_p);
                    r_ma    <= r_ss;
                    r_mb    <= MB_W'(r_cd);
                    r_ret   <= ST_DOT;
                    r_state <= ST_MUL;
                end
                // Take the first entry; later ones replace it when either the
                // direction or the energy is strictly closer.
                ST_DOT: begin
                    if (r_i == '0 || dot > r_best_dot || de < r_best_de) begin
                        r_best_dot <= dot;
                        r_best_de  <= de;
                        r_chosen   <= r_ent.id;
                        r_found    <= 1'b1;
                    end
                    r_i     <= r_i + CNT_W'(1);
                    r_state <= (r_i + CNT_W'(1) == r_count) ? ST_FINISH : ST_READ;
                end
                ST_FINISH: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_res.chosen_id  <= r_chosen;
                        r_res.found      <= r_found;
                        r_res.table_full <= r_full;
                        r_ovalid         <= 1'b1;
                        r_state          <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request taken while the previous one is in progress");

    a_found_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.data.found && o_res.data.table_full))
        else $error("result both found and table full");
`endif
endmodule

/* tb/sv/tb.sv */
// Self-checking bench for the nearest-entry table selector.
// Requests are driven on the falling edge and results are sampled on the
// rising edge. A scoreboard class holds its own copy of the entry table and
// predicts the one result that every request gives; results are compared in
// order, field by field.
module tb;
    import nts_pkg::*;

    logic i_clk;
    logic i_rst_n;

    nts_req_if req_if ();
    nts_res_if res_if ();

    nearest_table_select DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source)
    );

    // Scoreboard: a private model of the table plus the queue of pending results.
    class select_scoreboard;
        int unsigned      fill;
        logic [31:0]      ids    [MAX_ENTRIES];
        logic [15:0]      zen    [MAX_ENTRIES];
        logic [15:0]      azi    [MAX_ENTRIES];
        logic [13:0]      loge   [MAX_ENTRIES];
        t_res             pending[$];
        int unsigned      errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        // Polynomial sine on the first quarter, x in Q15.
        function automatic longint unsigned quarter_sine(longint unsigned x);
            longint unsigned x2, t;
            x2 = (x * x) >> 15;
            t  = 21024 - ((x2 * 2320) >> 15);
            t  = 51472 - ((x2 * t) >> 15);
            return (x * t) >> 15;
        endfunction

        function automatic longint sine(logic [15:0] a);
            logic [1:0]      q;
            longint unsigned x, s;
            q = a[15:14];
            x = longint'(a[13:0]) << 1;
            if (q[0]) begin
                x = 32768 - x;
            end
            s = quarter_sine(x);
            return q[1] ? -longint'(s) : longint'(s);
        endfunction

        function automatic longint cosine(logic [15:0] a);
            return sine(a + QUARTER_TURN);
        endfunction

        // Base-2 log with eight fraction bits, by repeated squaring.
        function automatic logic [13:0] log_q8(logic [31:0] v);
            int unsigned     ip;
            logic [7:0]      frac;
            longint unsigned m;
            ip   = 0;
            frac = 0;
            if (v == 0) begin
                return 0;
            end
            while (ip < 31 && (v >> (ip + 1)) != 0) begin
                ip++;
            end
            m = (longint'(v) << 30) >> ip;
            for (int i = 0; i < 8; i++) begin
                m    = (m * m) >> 30;
                frac = frac << 1;
                if (m >= (64'd1 << 31)) begin
                    frac[0] = 1'b1;
                    m       = m >> 1;
                end
            end
            return 14'((ip << 8) | frac);
        endfunction

        function automatic longint closeness(int k, logic [15:0] ez, logic [15:0] ea);
            longint ss, cc, cd;
            ss = sine(zen[k]) * sine(ez);
            cc = cosine(zen[k]) * cosine(ez);
            cd = cosine(azi[k] - ea);
            return ss * cd + cc * 32768;
        endfunction

        // Note an accepted request and queue the result it must give.
        function void note_request(t_req r);
            t_res        e;
            longint      best_dot, dot;
            logic [13:0] el, de, best_de;
            logic [16:0] zs, as_;
            e = '0;
            case (t_action'(r.action))
                ACT_LOAD: begin
                    if (fill >= MAX_ENTRIES) begin
                        e.table_full = 1'b1;
                    end else begin
                        zs  = r.zenith_min + r.zenith_max;
                        as_ = r.azimuth_min + r.azimuth_max;
                        ids[fill]  = r.entry_id;
                        zen[fill]  = zs[16:1];
                        azi[fill]  = as_[16:1] + ((r.azimuth_max < r.azimuth_min) ?
                                                  HALF_TURN : 16'd0);
                        loge[fill] = log_q8(r.entry_energy);
                        fill++;
                    end
                end
                ACT_QUERY: begin
                    el       = log_q8(r.event_energy);
                    best_dot = 0;
                    best_de  = 0;
                    for (int k = 0; k < fill; k++) begin
                        dot = closeness(k, r.event_zenith, r.event_azimuth);
                        de  = (loge[k] > el) ? loge[k] - el : el - loge[k];
                        if (k == 0 || dot > best_dot || de < best_de) begin
                            best_dot    = dot;
                            best_de     = de;
                            e.chosen_id = ids[k];
                            e.found     = 1'b1;
                        end
                    end
                end
                ACT_CLEAR: begin
                    fill = 0;
                end
                default: ;
            endcase
            pending.push_back(e);
        endfunction

        function void check_result(t_res got);
            t_res e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.chosen_id !== e.chosen_id) begin
                $display("%0t: chosen_id expected %h actual %h", $time, e.chosen_id,
                         got.chosen_id);
                errors++;
            end
            if (got.found !== e.found) begin
                $display("%0t: found expected %b actual %b", $time, e.found, got.found);
                errors++;
            end
            if (got.table_full !== e.table_full) begin
                $display("%0t: table_full expected %b actual %b", $time, e.table_full,
                         got.table_full);
                errors++;
            end
        endfunction
    endclass

    select_scoreboard board;
    bit               hold_results;   // long receiver hold-off in progress
    bit               steady_sink;    // no idling on the result side

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // Gap length: mostly short, now and then long.
    function automatic int gap_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    endfunction

    // Pick a random angle, often near the quadrant boundaries and extremes.
    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_energy();
        case ($urandom_range(0, 4))
            0:       return 32'($urandom_range(0, 3));
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic t_req random_request(t_action act);
        t_req r;
        r.action        = act;
        r.entry_id      = $urandom;
        r.zenith_min    = pick_angle();
        r.zenith_max    = pick_angle();
        r.azimuth_min   = pick_angle();
        r.azimuth_max   = pick_angle();
        r.entry_energy  = pick_energy();
        r.event_zenith  = pick_angle();
        r.event_azimuth = pick_angle();
        r.event_energy  = pick_energy();
        return r;
    endfunction

    // Offer one request and wait until the block takes it.
    task automatic send_request(t_req r);
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
        board.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic idle_sender();
        int n;
        n = gap_length();
        if (n > 0) begin
            req_if.valid <= 1'b0;
            req_if.data  <= random_request(t_action'($urandom_range(0, 3)));
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic send_and_idle(t_req r, bit gaps);
        send_request(r);
        if (gaps) begin
            idle_sender();
        end
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (board.pending.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Result side: sample on the rising edge, move ready on the falling edge.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                board.check_result(res_if.data);
            end
            @(negedge i_clk);
            if (hold_results) begin
                res_if.ready <= 1'b0;
            end else if (steady_sink) begin
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= ($urandom_range(0, 9) < 7);
            end
        end
    end

    // The long hold-off of the result side is counted here in cycles.
    task automatic hold_off_results(int cycles);
        hold_results = 1'b1;
        repeat (cycles) @(negedge i_clk);
        hold_results = 1'b0;
    endtask

    initial begin
        t_req r;
        int   roll;
        board        = new();
        hold_results = 1'b0;
        steady_sink  = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        i_rst_n      = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part: the empty-table query, the unused action code, zero
        // and full-scale energies, wrapped azimuth ranges and tied entries.
        send_and_idle(random_request(ACT_QUERY), 1'b0);
        send_and_idle(random_request(ACT_NONE), 1'b0);
        r = '0;
        r.action = ACT_LOAD;
        r.entry_id = 32'hFFFF_FFFF;
        r.zenith_max = 16'hFFFF;
        r.azimuth_min = 16'hFFFF;
        send_and_idle(r, 1'b0);
        r.entry_id = 32'h0;
        r.entry_energy = 32'hFFFF_FFFF;
        r.azimuth_min = 16'h0;
        r.azimuth_max = 16'hFFFF;
        r.zenith_min = 16'hFFFF;
        send_and_idle(r, 1'b0);
        r.entry_id = 32'd7;
        r.entry_energy = 32'd1;
        send_and_idle(r, 1'b0);
        r = '0;
        r.action = ACT_QUERY;
        send_and_idle(r, 1'b0);
        r.event_zenith = 16'hFFFF;
        r.event_azimuth = 16'hFFFF;
        r.event_energy = 32'hFFFF_FFFF;
        send_and_idle(r, 1'b0);
        r.event_energy = 32'd1;
        send_and_idle(r, 1'b0);
        for (int k = 0; k < 4; k++) begin
            send_and_idle(random_request(ACT_QUERY), 1'b1);
        end
        send_and_idle(random_request(ACT_CLEAR), 1'b0);
        send_and_idle(random_request(ACT_QUERY), 1'b0);

        // Fill the table to the brim, drop a few loads, and query it full,
        // while the result side holds off so that the block stalls its input.
        fork
            hold_off_results(400);
        join_none
        for (int k = 0; k < MAX_ENTRIES + 3; k++) begin
            send_and_idle(random_request(ACT_LOAD), 1'b0);
        end
        send_and_idle(random_request(ACT_QUERY), 1'b0);
        send_and_idle(random_request(ACT_QUERY), 1'b0);
        wait_drained();

        // Random part: mostly short tables of loads with queries on them,
        // a clear from time to time, and some noise.
        for (int n = 0; n < 320; n++) begin
            roll = $urandom_range(0, 99);
            steady_sink = (n >= 150 && n < 200);
            if (roll < 45) begin
                r = random_request(ACT_LOAD);
            end else if (roll < 88) begin
                r = random_request(ACT_QUERY);
            end else if (roll < 96) begin
                r = random_request(ACT_CLEAR);
            end else begin
                r = random_request(ACT_NONE);
            end
            send_and_idle(r, !(n >= 100 && n < 150));
            if (n == 250) begin
                wait_drained();
            end
        end
        steady_sink = 1'b0;

        wait_drained();
        repeat (200) @(negedge i_clk);
        if (board.errors == 0) begin
            $display("PASS nearest_table_select");
        end else begin
            $display("FAIL nearest_table_select");
        end
        $finish;
    end

    // Watchdog: ends the run if the roughly 400 requests do not finish in time.
    initial begin
        #20000000;
        $display("FAIL nearest_table_select");
        $finish;
    end
endmodule
